// ===== hw/rtl/dplt_pkg.sv =====
// Shared types and constants for the direct path liveness tracker.
package dplt_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_PROBE        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MARK_DIRECT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEND         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECEIVE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXPIRE_CHECK = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET_KEEP   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESET_FORGET = 3'd6;
  localparam logic [MODE_W-1:0] MODE_QUERY        = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_TIMEOUT   = 2'd1;

  localparam logic [CFG_W-1:0] PROBE_INTERVAL_RST = 32'd5000;
  localparam logic [CFG_W-1:0] PATH_TIMEOUT_RST   = 32'd15000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [PORT_W-1:0] port;
  } ep_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] endpoint_addr_high;
    logic [ADDR_W-1:0] endpoint_addr_low;
    logic [PORT_W-1:0] endpoint_port;
  } in_item_t;

  typedef struct packed {
    logic              flag;
    logic              has_direct;
    logic [ADDR_W-1:0] direct_addr_high;
    logic [ADDR_W-1:0] direct_addr_low;
    logic [PORT_W-1:0] direct_port;
    logic              is_verified;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic ins;
  } list_ctl_t;

endpackage

// ===== hw/rtl/dplt_cell.sv =====
// One verified-list cell: holds an endpoint, compares it and hands it to its left neighbor.
module dplt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dplt_pkg::ep_t     key,
  input  dplt_pkg::list_ctl_t ctl,
  input  logic              left_occ,
  input  dplt_pkg::ep_t     right_entry,
  output dplt_pkg::ep_t     entry,
  output logic              occ,
  output logic              hit
);

  dplt_pkg::ep_t entry_r, entry_nxt;
  logic          occ_r, occ_nxt;

  always_comb begin
    entry_nxt = entry_r;
    occ_nxt   = occ_r;
    if (ctl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctl.shift) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && left_occ && !occ_r) begin
      entry_nxt = key;
      occ_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign occ   = occ_r;
  assign hit   = occ_r && (entry_r == key);

endmodule

// ===== hw/rtl/direct_path_liveness_tracker_unit.sv =====
// Direct path liveness tracker: one peer's direct path, probe limiter and verified list.
// Takes one transaction per clock cycle while in_stall is low; each result appears in the
// output register the cycle after its transaction and is held there while out_stall is
// high, and in_stall stays high for as long as that result waits. The verified list is a
// row of VERIFIED_DEPTH cells (oldest at cell 0) that all compare the incoming endpoint
// in the same cycle; that match, ORed across the row, and the 64-bit time compare set the
// cycle time. Configuration writes are taken every cycle (cfg_ready is always high).
module direct_path_liveness_tracker_unit #(
  parameter int unsigned VERIFIED_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dplt_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dplt_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dplt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dplt_pkg::CFG_W-1:0]         cfg_data
);

  logic [dplt_pkg::CFG_W-1:0] probe_interval_r, probe_interval_nxt;
  logic [dplt_pkg::CFG_W-1:0] path_timeout_r, path_timeout_nxt;

  logic                        direct_valid_r, direct_valid_nxt;
  dplt_pkg::ep_t               direct_ep_r, direct_ep_nxt;
  logic                        probe_stamp_valid_r, probe_stamp_valid_nxt;
  logic [dplt_pkg::TIME_W-1:0] last_probe_r, last_probe_nxt;
  logic                        unans_valid_r, unans_valid_nxt;
  logic [dplt_pkg::TIME_W-1:0] first_unans_r, first_unans_nxt;

  logic                 out_valid_r, out_valid_nxt;
  dplt_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                        acc;
  dplt_pkg::ep_t               key;
  dplt_pkg::list_ctl_t         ctl;
  logic [dplt_pkg::TIME_W-1:0] probe_age;
  logic [dplt_pkg::TIME_W-1:0] unans_age;
  logic                        probe_ok;
  logic                        expire;
  logic                        flag;
  logic                        verified;
  logic                        hit_any;
  logic                        full;

  dplt_pkg::ep_t               entries [VERIFIED_DEPTH];
  logic [VERIFIED_DEPTH-1:0]   occs;
  logic [VERIFIED_DEPTH-1:0]   hits;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;

  assign key.addr_high = in_data.endpoint_addr_high;
  assign key.addr_low  = in_data.endpoint_addr_low;
  assign key.port      = in_data.endpoint_port;

  // verified list
  assign hit_any = |hits;
  assign full    = occs[VERIFIED_DEPTH-1];

  always_comb begin
    ctl.clear = acc && (in_data.mode == dplt_pkg::MODE_RESET_FORGET);
    ctl.shift = acc && (in_data.mode == dplt_pkg::MODE_MARK_DIRECT) && !hit_any && full;
    ctl.ins   = acc && (in_data.mode == dplt_pkg::MODE_MARK_DIRECT) && !hit_any && !full;
  end

  for (genvar i = 0; i < VERIFIED_DEPTH; i++) begin : g_cell
    logic          left_occ;
    dplt_pkg::ep_t right_entry;
    if (i == 0) begin : g_first
      assign left_occ = 1'b1;
    end else begin : g_mid
      assign left_occ = occs[i-1];
    end
    if (i == VERIFIED_DEPTH - 1) begin : g_last
      assign right_entry = key;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end
    dplt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key         (key),
      .ctl         (ctl),
      .left_occ    (left_occ),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .occ         (occs[i]),
      .hit         (hits[i])
    );
  end

  // path state
  assign probe_age = in_data.now - last_probe_r;
  assign unans_age = in_data.now - first_unans_r;
  assign probe_ok  = !direct_valid_r &&
                     !(probe_stamp_valid_r &&
                       (probe_age < {{(dplt_pkg::TIME_W-dplt_pkg::CFG_W){1'b0}}, probe_interval_r}));
  assign expire    = direct_valid_r && unans_valid_r &&
                     (unans_age > {{(dplt_pkg::TIME_W-dplt_pkg::CFG_W){1'b0}}, path_timeout_r});

  always_comb begin
    probe_interval_nxt = probe_interval_r;
    path_timeout_nxt   = path_timeout_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == dplt_pkg::REG_PROBE_INTERVAL) probe_interval_nxt = cfg_data;
      if (cfg_index == dplt_pkg::REG_PATH_TIMEOUT)   path_timeout_nxt   = cfg_data;
    end
  end

  always_comb begin
    direct_valid_nxt      = direct_valid_r;
    direct_ep_nxt         = direct_ep_r;
    probe_stamp_valid_nxt = probe_stamp_valid_r;
    last_probe_nxt        = last_probe_r;
    unans_valid_nxt       = unans_valid_r;
    first_unans_nxt       = first_unans_r;
    flag                  = 1'b0;
    verified              = hit_any;
    case (in_data.mode)
      dplt_pkg::MODE_PROBE: begin
        if (probe_ok) begin
          probe_stamp_valid_nxt = 1'b1;
          last_probe_nxt        = in_data.now;
          flag                  = 1'b1;
        end
      end
      dplt_pkg::MODE_MARK_DIRECT: begin
        flag             = !direct_valid_r || (direct_ep_r != key);
        direct_valid_nxt = 1'b1;
        direct_ep_nxt    = key;
        unans_valid_nxt  = 1'b0;
        verified         = 1'b1;
      end
      dplt_pkg::MODE_SEND: begin
        if (direct_valid_r && !unans_valid_r) begin
          unans_valid_nxt = 1'b1;
          first_unans_nxt = in_data.now;
        end
      end
      dplt_pkg::MODE_RECEIVE: begin
        unans_valid_nxt = 1'b0;
      end
      dplt_pkg::MODE_EXPIRE_CHECK: begin
        if (expire) begin
          direct_valid_nxt = 1'b0;
          direct_ep_nxt    = '0;
          unans_valid_nxt  = 1'b0;
          flag             = 1'b1;
        end
      end
      dplt_pkg::MODE_RESET_KEEP: begin
        direct_valid_nxt = 1'b0;
        direct_ep_nxt    = '0;
        unans_valid_nxt  = 1'b0;
      end
      dplt_pkg::MODE_RESET_FORGET: begin
        direct_valid_nxt = 1'b0;
        direct_ep_nxt    = '0;
        unans_valid_nxt  = 1'b0;
        verified         = 1'b0;
      end
      default: begin
      end
    endcase

    out_data_nxt.flag             = flag;
    out_data_nxt.has_direct       = direct_valid_nxt;
    out_data_nxt.direct_addr_high = direct_ep_nxt.addr_high;
    out_data_nxt.direct_addr_low  = direct_ep_nxt.addr_low;
    out_data_nxt.direct_port      = direct_ep_nxt.port;
    out_data_nxt.is_verified      = verified;

    out_valid_nxt = acc ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_interval_r    <= dplt_pkg::PROBE_INTERVAL_RST;
      path_timeout_r      <= dplt_pkg::PATH_TIMEOUT_RST;
      direct_valid_r      <= 1'b0;
      direct_ep_r         <= '0;
      probe_stamp_valid_r <= 1'b0;
      last_probe_r        <= '0;
      unans_valid_r       <= 1'b0;
      first_unans_r       <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      probe_interval_r <= probe_interval_nxt;
      path_timeout_r   <= path_timeout_nxt;
      out_valid_r      <= out_valid_nxt;
      if (acc) begin
        direct_valid_r      <= direct_valid_nxt;
        direct_ep_r         <= direct_ep_nxt;
        probe_stamp_valid_r <= probe_stamp_valid_nxt;
        last_probe_r        <= last_probe_nxt;
        unans_valid_r       <= unans_valid_nxt;
        first_unans_r       <= first_unans_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/dplt_checker.sv =====
// Port-level assertions for the direct path liveness tracker, bound to the top level.
module dplt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dplt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dplt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_no_direct_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_direct |->
      out_data.direct_addr_high == '0 && out_data.direct_addr_low == '0 &&
      out_data.direct_port == '0)
    else $error("direct endpoint not zero without a direct path");

  a_mark_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == dplt_pkg::MODE_MARK_DIRECT |=>
      out_valid && out_data.has_direct && out_data.is_verified &&
      out_data.direct_port == $past(in_data.endpoint_port))
    else $error("mark direct transaction gave a wrong result");

  a_forget_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == dplt_pkg::MODE_RESET_FORGET |=>
      out_valid && !out_data.has_direct && !out_data.is_verified && !out_data.flag)
    else $error("reset-forget transaction gave a wrong result");

endmodule

bind direct_path_liveness_tracker_unit dplt_checker u_dplt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_direct_path_liveness_tracker_unit.sv =====
// Self-checking testbench for the direct path liveness tracker: directed and random path events.
module tb_direct_path_liveness_tracker_unit;

  localparam int unsigned ENTRY_LIMIT = 8;
  localparam int unsigned POOL_SIZE = 12;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [dplt_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [dplt_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dplt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dplt_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dplt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dplt_pkg::CFG_W-1:0] cfg_data = '0;

  direct_path_liveness_tracker_unit #(
    .VERIFIED_DEPTH(ENTRY_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tracker state as predicted
  logic [dplt_pkg::CFG_W-1:0] probe_gap = dplt_pkg::PROBE_INTERVAL_RST;
  logic [dplt_pkg::CFG_W-1:0] expiry_limit = dplt_pkg::PATH_TIMEOUT_RST;
  logic direct_ok = 1'b0;
  dplt_pkg::ep_t direct_ep = '0;
  logic probe_stamped = 1'b0;
  logic [dplt_pkg::TIME_W-1:0] probe_stamp = '0;
  logic send_pending = 1'b0;
  logic [dplt_pkg::TIME_W-1:0] send_stamp = '0;
  dplt_pkg::ep_t verified_eps[$];

  dplt_pkg::out_item_t path_reports_q[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [dplt_pkg::TIME_W-1:0] tick = '0;
  dplt_pkg::ep_t ep_pool[POOL_SIZE];

  function automatic logic known_endpoint(dplt_pkg::ep_t e);
    foreach (verified_eps[i]) begin
      if (verified_eps[i] == e) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dplt_pkg::out_item_t predict_path_event(dplt_pkg::in_item_t ev);
    dplt_pkg::ep_t ep;
    dplt_pkg::out_item_t rpt;
    ep = {ev.endpoint_addr_high, ev.endpoint_addr_low, ev.endpoint_port};
    rpt = '0;
    case (ev.mode)
      dplt_pkg::MODE_PROBE: begin
        if (!direct_ok && !(probe_stamped && (ev.now - probe_stamp) < 64'(probe_gap))) begin
          probe_stamped = 1'b1;
          probe_stamp = ev.now;
          rpt.flag = 1'b1;
        end
      end
      dplt_pkg::MODE_MARK_DIRECT: begin
        rpt.flag = !direct_ok || (direct_ep != ep);
        direct_ok = 1'b1;
        direct_ep = ep;
        send_pending = 1'b0;
        if (!known_endpoint(ep)) begin
          if (verified_eps.size() >= ENTRY_LIMIT) void'(verified_eps.pop_front());
          verified_eps = {verified_eps, ep};
        end
      end
      dplt_pkg::MODE_SEND: begin
        if (direct_ok && !send_pending) begin
          send_pending = 1'b1;
          send_stamp = ev.now;
        end
      end
      dplt_pkg::MODE_RECEIVE: send_pending = 1'b0;
      dplt_pkg::MODE_EXPIRE_CHECK: begin
        if (direct_ok && send_pending && (ev.now - send_stamp) > 64'(expiry_limit)) begin
          direct_ok = 1'b0;
          direct_ep = '0;
          send_pending = 1'b0;
          rpt.flag = 1'b1;
        end
      end
      dplt_pkg::MODE_RESET_KEEP, dplt_pkg::MODE_RESET_FORGET: begin
        direct_ok = 1'b0;
        direct_ep = '0;
        send_pending = 1'b0;
        if (ev.mode == dplt_pkg::MODE_RESET_FORGET) verified_eps.delete();
      end
      default: ;
    endcase
    rpt.has_direct = direct_ok;
    if (direct_ok) begin
      rpt.direct_addr_high = direct_ep.addr_high;
      rpt.direct_addr_low = direct_ep.addr_low;
      rpt.direct_port = direct_ep.port;
    end
    rpt.is_verified = known_endpoint(ep);
    return rpt;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    dplt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (path_reports_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatches++;
      end else begin
        want = path_reports_q.pop_front();
        check_field("flag", 64'(want.flag), 64'(out_data.flag));
        check_field("has_direct", 64'(want.has_direct), 64'(out_data.has_direct));
        check_field("direct_addr_high", want.direct_addr_high, out_data.direct_addr_high);
        check_field("direct_addr_low", want.direct_addr_low, out_data.direct_addr_low);
        check_field("direct_port", 64'(want.direct_port), 64'(out_data.direct_port));
        check_field("is_verified", 64'(want.is_verified), 64'(out_data.is_verified));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("direct_path_liveness_tracker_unit: mismatch");
    $finish;
  end

  task automatic send_path_event(dplt_pkg::in_item_t ev);
    dplt_pkg::out_item_t rpt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    rpt = predict_path_event(ev);
    path_reports_q = {path_reports_q, rpt};
    @(negedge clk);
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (path_reports_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [dplt_pkg::CFG_IDX_W-1:0] idx,
                                logic [dplt_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dplt_pkg::REG_PROBE_INTERVAL) probe_gap = val;
    else if (idx == dplt_pkg::REG_PATH_TIMEOUT) expiry_limit = val;
    @(negedge clk);
  endtask

  task automatic set_registers(logic [dplt_pkg::CFG_W-1:0] gap,
                               logic [dplt_pkg::CFG_W-1:0] limit);
    wait_for_reports();
    write_register(dplt_pkg::REG_PROBE_INTERVAL, gap);
    write_register(REG_SPARE_A, $urandom);
    write_register(dplt_pkg::REG_PATH_TIMEOUT, limit);
    write_register(REG_SPARE_B, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic dplt_pkg::in_item_t path_event(logic [dplt_pkg::MODE_W-1:0] mode,
                                                    logic [dplt_pkg::TIME_W-1:0] now,
                                                    dplt_pkg::ep_t ep);
    dplt_pkg::in_item_t ev;
    ev.mode = mode;
    ev.now = now;
    ev.endpoint_addr_high = ep.addr_high;
    ev.endpoint_addr_low = ep.addr_low;
    ev.endpoint_port = ep.port;
    return ev;
  endfunction

  function automatic logic [dplt_pkg::TIME_W-1:0] advance_tick();
    logic [dplt_pkg::TIME_W-1:0] step;
    case ($urandom_range(9))
      0: step = '0;
      1, 2, 3: step = 64'($urandom_range(300));
      4: step = 64'(probe_gap) + 64'($urandom_range(2)) - 64'd1;
      5: step = 64'(expiry_limit) + 64'($urandom_range(2)) - 64'd1;
      6: step = {$urandom, $urandom};
      default: step = 64'($urandom);
    endcase
    tick = tick + step;
    return tick;
  endfunction

  function automatic dplt_pkg::in_item_t draw_path_event();
    int unsigned pick;
    logic [dplt_pkg::MODE_W-1:0] mode;
    dplt_pkg::ep_t ep;
    pick = $urandom_range(99);
    if (pick < 18) mode = dplt_pkg::MODE_PROBE;
    else if (pick < 33) mode = dplt_pkg::MODE_MARK_DIRECT;
    else if (pick < 50) mode = dplt_pkg::MODE_SEND;
    else if (pick < 60) mode = dplt_pkg::MODE_RECEIVE;
    else if (pick < 78) mode = dplt_pkg::MODE_EXPIRE_CHECK;
    else if (pick < 82) mode = dplt_pkg::MODE_RESET_KEEP;
    else if (pick < 84) mode = dplt_pkg::MODE_RESET_FORGET;
    else mode = dplt_pkg::MODE_QUERY;
    if ($urandom_range(7) == 0) ep = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    else ep = ep_pool[$urandom_range(POOL_SIZE - 1)];
    return path_event(mode, advance_tick(), ep);
  endfunction

  task automatic test_directed_events();
    dplt_pkg::ep_t ep_zero;
    dplt_pkg::ep_t ep_ones;
    dplt_pkg::ep_t ep_port1;
    logic [dplt_pkg::TIME_W-1:0] t0;
    logic [dplt_pkg::TIME_W-1:0] t1;
    logic [dplt_pkg::TIME_W-1:0] t2;
    ep_zero = '0;
    ep_ones = '1;
    ep_port1 = '0;
    ep_port1.port = 16'd1;
    t0 = 64'hFFFF_FFFF_FFFF_F000;
    t1 = t0 + 64'd6000;
    t2 = t1 + 64'd50000;
    send_path_event(path_event(dplt_pkg::MODE_QUERY, t0, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_PROBE, t0, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_PROBE, t0 + 64'd4999, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_PROBE, t0 + 64'd5000, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_MARK_DIRECT, t0 + 64'd5000, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_PROBE, t0 + 64'd20000, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_MARK_DIRECT, t0 + 64'd5500, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_SEND, t1, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_SEND, t1 + 64'd100, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_EXPIRE_CHECK, t1 + 64'd15000, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_EXPIRE_CHECK, t1 + 64'd15001, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_SEND, t1 + 64'd15002, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_EXPIRE_CHECK, t1 + 64'd40000, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_MARK_DIRECT, t2, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_MARK_DIRECT, t2, ep_port1));
    send_path_event(path_event(dplt_pkg::MODE_SEND, t2 + 64'd1, ep_port1));
    send_path_event(path_event(dplt_pkg::MODE_RECEIVE, t2 + 64'd2, ep_port1));
    send_path_event(path_event(dplt_pkg::MODE_EXPIRE_CHECK, t2 + 64'd90000, ep_port1));
    send_path_event(path_event(dplt_pkg::MODE_RESET_KEEP, t2 + 64'd90001, ep_port1));
    send_path_event(path_event(dplt_pkg::MODE_QUERY, t2 + 64'd90002, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_MARK_DIRECT, t2 + 64'd90003, ep_ones));
    send_path_event(path_event(dplt_pkg::MODE_RESET_FORGET, t2 + 64'd90004, ep_zero));
    send_path_event(path_event(dplt_pkg::MODE_QUERY, t2 + 64'd90005, ep_ones));
    tick = t2 + 64'd90005;
  endtask

  task automatic test_random_events(int unsigned count, logic [dplt_pkg::CFG_W-1:0] gap,
                                    logic [dplt_pkg::CFG_W-1:0] limit);
    set_registers(gap, limit);
    foreach (ep_pool[i]) ep_pool[i] = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    ep_pool[0] = '0;
    ep_pool[1] = '1;
    ep_pool[2] = ep_pool[3];
    ep_pool[2].port = ep_pool[3].port ^ 16'h0001;
    ep_pool[4] = ep_pool[5];
    ep_pool[4].addr_high = ep_pool[5].addr_high ^ 64'h8000_0000_0000_0000;
    repeat (count) send_path_event(draw_path_event());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 48;
    test_directed_events();
    test_random_events(350, dplt_pkg::PROBE_INTERVAL_RST, dplt_pkg::PATH_TIMEOUT_RST);
    test_random_events(300, '0, '0);
    send_idle_pct = 48;
    recv_idle_pct = 27;
    test_random_events(350, '1, '1);
    test_random_events(350, 32'd1, 32'd7);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_events(350, $urandom_range(20000), $urandom_range(40000));
    test_random_events(300, 32'd64, 32'd200);
    wait_for_reports();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && path_reports_q.size() == 0)
      $display("direct_path_liveness_tracker_unit: match");
    else
      $display("direct_path_liveness_tracker_unit: mismatch");
    $finish;
  end

endmodule

// ===== direct_path_liveness_tracker_unit.f =====
hw/rtl/dplt_pkg.sv
hw/rtl/dplt_cell.sv
hw/rtl/direct_path_liveness_tracker_unit.sv
hw/rtl/dplt_checker.sv
test/tb_direct_path_liveness_tracker_unit.sv
